>>> sv/fir_filter_streaming_macros.svh
// Assertion shorthands used by the checker file.
`ifndef FIR_FILTER_STREAMING_MACROS_SVH
`define FIR_FILTER_STREAMING_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define FIRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define FIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/firs_pkg.sv
package firs_pkg;

	// Field widths
	localparam int DATA_W     = 16;
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 6;
	localparam int TAP_W      = 7;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 16;

	// Defaults
	localparam int MAX_TAPS_DEF = 64;
	localparam logic [TAP_W-1:0] TAP_RESET = 7'd64;

	// Commands carried on s_tuser
	localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Sequencer to multiply-accumulate unit
	typedef struct packed {
		logic start;     // clear accumulator for a new sample
		logic rd_valid;  // RAM read data valid this cycle
		logic rd_last;   // this read is the last tap
	} firs_mac_ctl_t;

endpackage

>>> sv/firs_ram.sv
module firs_ram #(
	parameter int W  = 16,
	parameter int D  = 64,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/firs_mac.sv
module firs_mac import firs_pkg::*; #(
	parameter int ACC_W = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  firs_mac_ctl_t            ctl,
	input  logic signed [DATA_W-1:0] coef,
	input  logic signed [DATA_W-1:0] smp,
	output logic                     done,
	output logic [DATA_W-1:0]        filtered,
	output logic                     saturated
);

	localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'sd16384);
	localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(64'sd1 << 30);
	localparam logic signed [ACC_W-1:0] NEG_LIM = -POS_LIM;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  rnd_sum;

	// Multiply one tap, then accumulate the registered product
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(coef) * PROD_W'(smp);
		if (ctl.start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Track the product stage and flag the final sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= ctl.rd_valid;
			last_s2  <= ctl.rd_valid && ctl.rd_last;
			if (ctl.start) begin
				done_q <= 1'b0;
			end else if (valid_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	// Round half up, shift by 15, clip to 16 bits
	assign rnd_sum = acc_q + RND;

	always_comb begin
		saturated = 1'b1;
		if (rnd_sum >= POS_LIM) begin
			filtered = 16'h7fff;
		end else if (rnd_sum < NEG_LIM) begin
			filtered = 16'h8000;
		end else begin
			filtered  = rnd_sum[15 +: DATA_W];
			saturated = 1'b0;
		end
	end

	assign done = done_q;

endmodule

>>> sv/fir_filter_streaming.sv
// Filter transaction: once N samples are held (N = taps in use), the tap loop runs and
// the result is registered; s_tready rises again with m_tvalid, so the single shared
// multiply-accumulate unit ends one sample before the next; a stalled output waits.
// Load, clear and unknown commands give no result.
// Reset (arst_n low, asynchronous) clears control state; the coefficient RAM is
// then swept to zero, during which s_tready stays low.
module fir_filter_streaming import firs_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] coef_index, [21:6] value, [23:22] zero
	input  logic [CMD_W-1:0]     s_tuser,   // [1:0] command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] filtered
	output logic [0:0]           m_tuser,   // [0] saturated
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TAP_W-1:0]     cfg_data
);

	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int NW    = $clog2(MAX_TAPS + 1);
	localparam int CW    = (NW > TAP_W) ? NW : TAP_W;
	localparam int ACC_W = PROD_W + AW + 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_MAC   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]        state_q;
	logic [TAP_W-1:0]  tap_q;
	logic [NW-1:0]     fill_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     h_q;
	logic [AW-1:0]     clr_q;
	logic              rd_valid_s1;
	logic              rd_last_s1;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  idx;
	logic [DATA_W-1:0] val;
	logic              accept;
	logic              idx_ok;
	logic [CW-1:0]     tap_w;
	logic [NW-1:0]     n_taps;
	logic [AW-1:0]     nm1;
	logic [NW-1:0]     fill_next;
	logic [AW:0]       start_wide;
	logic [AW-1:0]     start_addr;
	logic [AW-1:0]     wp_next;
	logic [AW-1:0]     h_next;
	logic              out_free;
	logic              out_load;

	logic              coef_we;
	logic [AW-1:0]     coef_waddr;
	logic [DATA_W-1:0] coef_wdata;
	logic [DATA_W-1:0] coef_rd;
	logic              hist_we;
	logic [DATA_W-1:0] hist_rd;

	firs_mac_ctl_t     mac_ctl;
	logic              mac_done;
	logic [DATA_W-1:0] mac_filtered;
	logic              mac_saturated;

	// Unpack the input transaction
	assign cmd      = s_tuser;
	assign idx      = s_tdata[IDX_W-1:0];
	assign val      = s_tdata[IDX_W +: DATA_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DRAIN) && mac_done && out_free;

	// Clamp the tap count to 1..MAX_TAPS
	assign tap_w = CW'(tap_q);
	always_comb begin
		if (tap_w == '0) begin
			n_taps = NW'(1);
		end else if (tap_w > CW'(MAX_TAPS)) begin
			n_taps = NW'(MAX_TAPS);
		end else begin
			n_taps = NW'(tap_w);
		end
	end
	assign nm1 = AW'(n_taps - NW'(1));

	assign fill_next = (fill_q == NW'(MAX_TAPS)) ? fill_q : fill_q + NW'(1);
	assign wp_next   = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
	assign h_next    = (h_q == AW'(MAX_TAPS - 1)) ? '0 : h_q + AW'(1);

	// Oldest sample in use sits N-1 slots behind the newest, modulo the depth
	always_comb begin
		if (wp_q >= nm1) begin
			start_wide = {1'b0, wp_q} - {1'b0, nm1};
		end else begin
			start_wide = {1'b0, wp_q} + (AW + 1)'(MAX_TAPS) - {1'b0, nm1};
		end
	end
	assign start_addr = start_wide[AW-1:0];

	// Coefficient RAM: zero sweep after reset, else load commands
	assign idx_ok = 32'(idx) < 32'(MAX_TAPS);
	always_comb begin
		if (state_q == ST_CLEAR) begin
			coef_we    = 1'b1;
			coef_waddr = clr_q;
			coef_wdata = '0;
		end else begin
			coef_we    = accept && (cmd == CMD_LOAD) && idx_ok;
			coef_waddr = AW'(idx);
			coef_wdata = val;
		end
	end

	assign hist_we = accept && (cmd == CMD_FILTER);

	firs_ram #(.W(DATA_W), .D(MAX_TAPS), .AW(AW)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (j_q),
		.rdata (coef_rd)
	);

	firs_ram #(.W(DATA_W), .D(MAX_TAPS), .AW(AW)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (val),
		.raddr (h_q),
		.rdata (hist_rd)
	);

	assign mac_ctl.start    = hist_we;
	assign mac_ctl.rd_valid = rd_valid_s1;
	assign mac_ctl.rd_last  = rd_last_s1;

	firs_mac #(.ACC_W(ACC_W)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.coef      (coef_rd),
		.smp       (hist_rd),
		.done      (mac_done),
		.filtered  (mac_filtered),
		.saturated (mac_saturated)
	);

	// Sequencer: clear sweep, command dispatch, tap loop, drain to output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			tap_q       <= TAP_RESET;
			fill_q      <= '0;
			wp_q        <= '0;
			j_q         <= '0;
			h_q         <= '0;
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tap_q <= cfg_data;
			end
			rd_valid_s1 <= (state_q == ST_MAC);
			rd_last_s1  <= (state_q == ST_MAC) && (j_q == nm1);
			// Raise valid on a new result, else drop it once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_FILTER: begin
								wp_q   <= wp_next;
								fill_q <= fill_next;
								if (fill_next >= n_taps) begin
									j_q     <= '0;
									h_q     <= start_addr;
									state_q <= ST_MAC;
								end
							end
							CMD_CLEAR: begin
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MAC: begin
					j_q <= j_q + AW'(1);
					h_q <= h_next;
					if (j_q == nm1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= mac_filtered;
			m_tuser_q <= mac_saturated;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

>>> sv/firs_checker.sv
`include "fir_filter_streaming_macros.svh"

module firs_checker import firs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [CMD_W-1:0]     s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [TAP_W-1:0]     cfg_data
);

	// Hold a stalled result
	`FIRS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// A clipped result sits at one of the rails
	`FIRS_ASSERT_SAME(a_sat_rail, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 16'h7fff || m_tdata == 16'h8000, "saturation flag without rail value")

	// Load and clear transactions never raise a result
	`FIRS_ASSERT_NEXT(a_no_result_cmd, clk, arst_n, s_tvalid && s_tready && s_tuser != CMD_FILTER, !$rose(m_tvalid), "result after a non-filter transaction")

	// A new result appears just as the input side turns ready again
	`FIRS_ASSERT_SAME(a_rise_busy, clk, arst_n, $rose(m_tvalid), s_tready, "result raised without a finished tap loop")

endmodule

bind fir_filter_streaming firs_checker u_firs_checker (.*);
